### hdl/ssbx_pkg.sv
`timescale 1ns / 1ps
// Shared constants, stage payload type and GF(2^8) helper functions
// for the SEED S-box datapath. No dependencies.
package ssbx_pkg;

  localparam logic [7:0] POLY_RESET = 8'h63;
  localparam logic [7:0] BOX1_POWER = 8'd247;
  localparam logic [7:0] BOX2_POWER = 8'd251;
  localparam logic [7:0] BOX1_CONST = 8'hA9;
  localparam logic [7:0] BOX2_CONST = 8'h38;
  localparam logic [7:0] TOP_BIT    = 8'h80;

  // One square-and-multiply stage for each bit of the exponent.
  localparam int NUM_POW_STAGES = 8;

  // Bit (7-c) of row r is the matrix entry at row r, column c.
  localparam logic [7:0] BOX1_ROWS [8] = '{
    8'h8A, 8'hFE, 8'h85, 8'h42, 8'h45, 8'h21, 8'h88, 8'h14
  };
  localparam logic [7:0] BOX2_ROWS [8] = '{
    8'h45, 8'h85, 8'hFE, 8'h21, 8'h8A, 8'h88, 8'h42, 8'h14
  };

  typedef struct packed {
    logic       func;
    logic [7:0] base;
    logic [7:0] acc;
  } ssbx_stage_t;

  // Shift-and-add multiply modulo x^8 + poly.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = 8'h00;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ aa;
      end
      aa = {aa[6:0], 1'b0} ^ (((aa & TOP_BIT) != 8'h00) ? poly : 8'h00);
    end
    return acc;
  endfunction

  // Affine output map of the selected box.
  function automatic logic [7:0] affine_map(input logic sel, input logic [7:0] v);
    logic [7:0] res;
    res = 8'h00;
    for (int r = 0; r < 8; r++) begin
      res[7-r] = ^((sel ? BOX2_ROWS[r] : BOX1_ROWS[r]) & v);
    end
    return res ^ (sel ? BOX2_CONST : BOX1_CONST);
  endfunction

endpackage

### hdl/ssbx_pow_stage.sv
`timescale 1ns / 1ps
// One pipelined square-and-multiply step of the GF(2^8) power.
// Depends on ssbx_pkg.
module ssbx_pow_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           poly,
  input  logic                 pow1_bit,
  input  logic                 pow2_bit,
  input  logic                 up_valid,
  input  ssbx_pkg::ssbx_stage_t up_data,
  output logic                 up_stall,
  output logic                 dn_valid,
  output ssbx_pkg::ssbx_stage_t dn_data,
  input  logic                 dn_stall
);

  logic                  valid;
  ssbx_pkg::ssbx_stage_t data;
  ssbx_pkg::ssbx_stage_t data_next;
  logic                  mul_en;

  // The stage takes a new transfer whenever it is empty or its contents move on.
  assign up_stall = valid && dn_stall;

  always_comb begin
    mul_en         = up_data.func ? pow2_bit : pow1_bit;
    data_next.func = up_data.func;
    data_next.base = ssbx_pkg::gf_mul(up_data.base, up_data.base, poly);
    data_next.acc  = mul_en ? ssbx_pkg::gf_mul(up_data.acc, up_data.base, poly)
                            : up_data.acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

### hdl/seed_sbox_compute_top.sv
`timescale 1ns / 1ps
// Top level of the table-free SEED S-box: power pipeline and affine output stage.
// Depends on ssbx_pkg and ssbx_pow_stage.

// The block substitutes one byte per clock cycle while the output is not stalled.
// Each byte passes through eight square-and-multiply stages, each one GF(2^8)
// multiply deep, that raise it to the power 247 or 251, and a final register
// applies the bit-matrix and constant of the selected box. Every stage holds its
// item under stall and fills bubbles, so a waiting result does not block input
// while the pipeline has room. The reduction polynomial register should be
// written only while the pipeline is empty.
module seed_sbox_compute_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] sbox_out
);

  localparam int N = ssbx_pkg::NUM_POW_STAGES;

  logic [7:0]            poly;
  logic [N:0]            valid_s;
  logic [N:0]            stall_s;
  ssbx_pkg::ssbx_stage_t data_s [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= ssbx_pkg::POLY_RESET;
    end else if (cfg_wr_en) begin
      poly <= cfg_wr_data;
    end
  end

  assign valid_s[0]     = in_valid;
  assign data_s[0].func = func;
  assign data_s[0].base = in_byte;
  assign data_s[0].acc  = 8'h01;
  assign in_stall       = stall_s[0];

  for (genvar g = 0; g < N; g++) begin : g_pow
    ssbx_pow_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .poly     (poly),
      .pow1_bit (ssbx_pkg::BOX1_POWER[g]),
      .pow2_bit (ssbx_pkg::BOX2_POWER[g]),
      .up_valid (valid_s[g]),
      .up_data  (data_s[g]),
      .up_stall (stall_s[g]),
      .dn_valid (valid_s[g+1]),
      .dn_data  (data_s[g+1]),
      .dn_stall (stall_s[g+1])
    );
  end

  assign stall_s[N] = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall_s[N]) begin
      out_valid <= valid_s[N];
    end
  end

  always_ff @(posedge clk) begin
    if (valid_s[N] && !stall_s[N]) begin
      sbox_out <= ssbx_pkg::affine_map(data_s[N].func, data_s[N].acc);
    end
  end

endmodule

### hdl/ssbx_checker.sv
`timescale 1ns / 1ps
// Port-level checks of seed_sbox_compute_top and the bind that attaches them.
// Depends on ssbx_pkg and seed_sbox_compute_top.
module ssbx_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       func,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] sbox_out
);

  // A held result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sbox_out))
    else $error("output changed while stalled");

  // Input is held back only when the output is full and stalled.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // With no backpressure, a transferred item reaches the output through the power stages and the output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
    ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

  // A zero byte maps to the additive constant of box 1 alone.
  a_zero_box1: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !func && in_byte == 8'h00
    ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
    ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
    |=> sbox_out == ssbx_pkg::BOX1_CONST)
    else $error("zero input did not give the box constant");

endmodule

bind seed_sbox_compute_top ssbx_checker u_ssbx_checker (.*);

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for seed_sbox_compute_top: random bytes through both S-boxes
// under several reduction polynomials, with random gaps and stalls on both sides.
// Depends on the RTL in hdl/ (ssbx_pkg, seed_sbox_compute_top and its stages).
module testbench;

  typedef struct {
    logic       sel;
    logic [7:0] data;
  } sbox_req_t;

  localparam int PIPE_DRAIN = 20;
  localparam int RANDOM_PER_PHASE = 236;

  // Affine matrix rows of both boxes: bit (7-c) of row r is entry (r, c).
  localparam logic [7:0] BOX1_MATRIX [8] = '{
    8'h8A, 8'hFE, 8'h85, 8'h42, 8'h45, 8'h21, 8'h88, 8'h14
  };
  localparam logic [7:0] BOX2_MATRIX [8] = '{
    8'h45, 8'h85, 8'hFE, 8'h21, 8'h8A, 8'h88, 8'h42, 8'h14
  };
  localparam logic [7:0] BOX1_XOR = 8'hA9;
  localparam logic [7:0] BOX2_XOR = 8'h38;
  localparam logic [7:0] BOX1_EXP = 8'd247;
  localparam logic [7:0] BOX2_EXP = 8'd251;
  localparam logic [7:0] DEFAULT_POLY = 8'h63;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       func = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] sbox_out;

  sbox_req_t  pending_bytes_q[$];
  logic [7:0] expected_sbox_q[$];
  logic [7:0] poly_model = DEFAULT_POLY;
  logic [7:0] expected_byte;
  bit         idle_on = 1'b1;
  int         fail_count = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         flow_left = 0;

  seed_sbox_compute_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sbox_out   (sbox_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Multiply in GF(2)[x] / (x^8 + poly), most significant bit of b first.
  function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] poly);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? poly : 8'h00);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] seed_sbox_predict(input logic sel, input logic [7:0] data,
                                                   input logic [7:0] poly);
    logic [7:0] power_exp;
    logic [7:0] pw;
    logic [7:0] row;
    logic [7:0] res;
    power_exp = sel ? BOX2_EXP : BOX1_EXP;
    pw = 8'h01;
    for (int i = 7; i >= 0; i--) begin
      pw = field_product(pw, pw, poly);
      if (power_exp[i]) begin
        pw = field_product(pw, data, poly);
      end
    end
    res = 8'h00;
    for (int r = 0; r < 8; r++) begin
      row = sel ? BOX2_MATRIX[r] : BOX1_MATRIX[r];
      res[7-r] = ^(row & pw);
    end
    return res ^ (sel ? BOX2_XOR : BOX1_XOR);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (!idle_on || pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 12);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  // Driver: the expectation is taken from the payload at the transfer itself.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_sbox_q.push_back(seed_sbox_predict(func, in_byte, poly_model));
        void'(pending_bytes_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // A stalled transfer keeps its payload.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes_q.size() > 0) begin
        in_valid <= 1'b1;
        func     <= pending_bytes_q[0].sel;
        in_byte  <= pending_bytes_q[0].data;
        send_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each output transfer and drives a random stall pattern.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_sbox_q.size() == 0) begin
          $error("sbox_out: no result expected, actual %02h", sbox_out);
          fail_count++;
        end else begin
          expected_byte = expected_sbox_q.pop_front();
          if (sbox_out !== expected_byte) begin
            $error("sbox_out: expected %02h, actual %02h", expected_byte, sbox_out);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if (flow_left > 0) begin
          flow_left--;
        end else begin
          stall_left = idle_len();
          flow_left = $urandom_range(0, 8);
        end
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_byte(input logic sel, input logic [7:0] data);
    sbox_req_t req;
    req.sel  = sel;
    req.data = data;
    pending_bytes_q.push_back(req);
  endtask

  task automatic queue_random(input int count);
    logic [7:0] corner [5];
    logic [7:0] data;
    corner = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        data = corner[$urandom_range(0, 4)];
      end else begin
        data = 8'($urandom_range(0, 255));
      end
      queue_byte(1'($urandom_range(0, 1)), data);
    end
  endtask

  // Wait until every queued byte has been sent and every result has come back,
  // then give the pipeline time to settle before the polynomial changes.
  task automatic wait_until_empty();
    while (pending_bytes_q.size() > 0 || in_valid || expected_sbox_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_poly(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    poly_model = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] poly_plan [7];
    logic [7:0] edge_bytes [8];
    poly_plan  = '{8'h00, 8'hFF, 8'h1B, 8'h00, 8'h63, 8'h00, 8'h01};
    edge_bytes = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h02};
    poly_plan[3] = 8'($urandom_range(0, 255));
    poly_plan[5] = 8'($urandom_range(0, 255));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed corners under the reset polynomial; a zero byte gives the constant alone.
    foreach (edge_bytes[i]) begin
      queue_byte(1'b0, edge_bytes[i]);
      queue_byte(1'b1, edge_bytes[i]);
    end
    queue_random(RANDOM_PER_PHASE);
    wait_until_empty();

    for (int p = 0; p < 7; p++) begin
      idle_on = (p != 2);
      write_poly(poly_plan[p]);
      queue_byte(1'b0, 8'h00);
      queue_byte(1'b1, 8'h00);
      queue_random(RANDOM_PER_PHASE / 2);
      // Hold the sender until the pipeline has emptied, then carry on.
      while (pending_bytes_q.size() > 0 || in_valid || expected_sbox_q.size() > 0) begin
        @(posedge clk);
      end
      queue_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
      wait_until_empty();
    end

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
